>>> sv/red_pkg.sv
package red_pkg;

   localparam int SAMPLES_DEF = 32;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam logic [15:0] SYNC_PATTERN = 16'hAAAA;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;

   // pi as unsigned fixed point with 40 fraction bits, split for two narrow products.
   localparam logic [41:0] PI_Q40 = 42'h3243F6A8885;
   localparam int PI_SPLIT = 21;
   localparam int PI_FRAC = 40;

   typedef enum logic [1:0] {
      FRAME_HUNT,
      FRAME_HEADER,
      FRAME_DATA
   } frame_state_type;

   typedef enum logic {
      EMIT_IDLE,
      EMIT_RUN
   } emit_state_type;

   typedef struct packed {
      logic [8:0]  channel;
      logic [31:0] timestamp;
      logic        pulse_flag;
      logic        bank;
      logic [15:0] good_events;
      logic [15:0] bad_events;
      logic [15:0] skipped_words;
   } event_desc_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } bank_free_type;

   function automatic logic [15:0] sat_inc(input logic [15:0] count);
      return (count == COUNT_MAX) ? count : count + 16'd1;
   endfunction

endpackage

>>> sv/red_ram.sv
module red_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/red_evq.sv
module red_evq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  red_pkg::event_desc_type push_data,
   output logic                    full,
   input  logic                    pop,
   output logic                    pop_valid,
   output red_pkg::event_desc_type pop_data
);

   red_pkg::event_desc_type entries_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign full = count_ff[1];
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data = entries_ff[rd_ptr_ff];

endmodule

>>> sv/red_front.sv
module red_front #(
   parameter int SAMPLES = red_pkg::SAMPLES_DEF,
   parameter int SAMPLE_BITS = red_pkg::SAMPLE_BITS_DEF,
   localparam int CW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1,
   localparam int AW = CW + 1,
   localparam int DW = 16 + SAMPLE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [31:0]             req_word,
   input  logic                    csr_write_enable,
   input  logic [7:0]              csr_write_data,
   output logic                    wr_en,
   output logic [AW-1:0]           wr_addr,
   output logic [DW-1:0]           wr_data,
   output logic                    q_push,
   output red_pkg::event_desc_type q_data,
   input  logic                    q_full,
   input  red_pkg::bank_free_type  bank_free
);

   localparam logic [CW-1:0] LAST_IDX = CW'(SAMPLES - 1);

   red_pkg::frame_state_type state_ff;
   red_pkg::frame_state_type state_in;

   logic [CW-1:0] cnt_ff;
   logic [CW-1:0] cnt_in;
   logic          bank_ff;
   logic          bank_in;
   logic [1:0]    busy_ff;
   logic [1:0]    busy_in;
   logic [15:0]   good_ff;
   logic [15:0]   good_in;
   logic [15:0]   bad_ff;
   logic [15:0]   bad_in;
   logic [15:0]   skip_ff;
   logic [15:0]   skip_in;
   logic [7:0]    offset_ff;
   logic [15:0]   sync_hold_ff;
   logic [15:0]   sync_hold_in;
   logic [8:0]    chan_ff;
   logic [8:0]    chan_in;
   logic          pulse_ff;
   logic          pulse_in;
   logic [15:0]   ts_low_ff;
   logic [15:0]   ts_low_in;

   logic accept;
   logic is_sync;
   logic last_sample;

   assign accept = req_valid && req_ready;
   assign is_sync = (req_word[15:0] == red_pkg::SYNC_PATTERN);
   assign last_sample = (cnt_ff == LAST_IDX);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         red_pkg::FRAME_HUNT: begin
            if (accept && is_sync) begin
               state_in = red_pkg::FRAME_HEADER;
            end
         end
         red_pkg::FRAME_HEADER: begin
            if (accept) begin
               state_in = red_pkg::FRAME_DATA;
            end
         end
         red_pkg::FRAME_DATA: begin
            if (accept && (is_sync || last_sample)) begin
               state_in = red_pkg::FRAME_HUNT;
            end
         end
         default: begin
            state_in = red_pkg::FRAME_HUNT;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b1;
      cnt_in = cnt_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      good_in = good_ff;
      bad_in = bad_ff;
      skip_in = skip_ff;
      sync_hold_in = sync_hold_ff;
      chan_in = chan_ff;
      pulse_in = pulse_ff;
      ts_low_in = ts_low_ff;
      wr_en = 1'b0;
      q_push = 1'b0;
      if (bank_free.valid) begin
         busy_in[bank_free.bank] = 1'b0;
      end
      case (state_ff)
         red_pkg::FRAME_HUNT: begin
            if (accept) begin
               if (is_sync) begin
                  sync_hold_in = req_word[31:16];
               end else begin
                  skip_in = red_pkg::sat_inc(skip_ff);
               end
            end
         end
         red_pkg::FRAME_HEADER: begin
            if (accept) begin
               chan_in = {1'b0, req_word[7:0]} + {1'b0, offset_ff};
               pulse_in = req_word[8];
               ts_low_in = req_word[24:9];
               cnt_in = '0;
            end
         end
         red_pkg::FRAME_DATA: begin
            req_ready = !busy_ff[bank_ff] && !q_full;
            if (accept) begin
               if (is_sync) begin
                  bad_in = red_pkg::sat_inc(bad_ff);
                  cnt_in = '0;
               end else begin
                  wr_en = 1'b1;
                  if (last_sample) begin
                     good_in = red_pkg::sat_inc(good_ff);
                     q_push = 1'b1;
                     busy_in[bank_ff] = 1'b1;
                     bank_in = ~bank_ff;
                     cnt_in = '0;
                  end else begin
                     cnt_in = cnt_ff + CW'(1);
                  end
               end
            end
         end
         default: begin
            req_ready = 1'b1;
         end
      endcase
   end

   assign wr_addr = {bank_ff, cnt_ff};
   assign wr_data = {req_word[31:16], req_word[SAMPLE_BITS-1:0]};

   always_comb begin
      q_data.channel = chan_ff;
      q_data.timestamp = {sync_hold_ff, ts_low_ff};
      q_data.pulse_flag = pulse_ff;
      q_data.bank = bank_ff;
      q_data.good_events = good_in;
      q_data.bad_events = bad_ff;
      q_data.skipped_words = skip_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= red_pkg::FRAME_HUNT;
         cnt_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= 2'b00;
         good_ff <= 16'd0;
         bad_ff <= 16'd0;
         skip_ff <= 16'd0;
         offset_ff <= 8'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
         good_ff <= good_in;
         bad_ff <= bad_in;
         skip_ff <= skip_in;
         if (csr_write_enable) begin
            offset_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      sync_hold_ff <= sync_hold_in;
      chan_ff <= chan_in;
      pulse_ff <= pulse_in;
      ts_low_ff <= ts_low_in;
   end

endmodule

>>> sv/red_back.sv
module red_back #(
   parameter int SAMPLES = red_pkg::SAMPLES_DEF,
   parameter int SAMPLE_BITS = red_pkg::SAMPLE_BITS_DEF,
   localparam int CW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1,
   localparam int AW = CW + 1,
   localparam int DW = 16 + SAMPLE_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  red_pkg::event_desc_type q_data,
   output logic                    rd_en,
   output logic [AW-1:0]           rd_addr,
   input  logic [DW-1:0]           rd_data,
   output red_pkg::bank_free_type  bank_free,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [8:0]              rsp_channel,
   output logic [31:0]             rsp_timestamp,
   output logic                    rsp_pulse_flag,
   output logic [4:0]              rsp_sample_index,
   output logic [15:0]             rsp_magnitude,
   output logic signed [17:0]      rsp_phase_radians,
   output logic                    rsp_last,
   output logic [15:0]             rsp_good_events,
   output logic [15:0]             rsp_bad_events,
   output logic [15:0]             rsp_skipped_words
);

   localparam logic [CW-1:0] LAST_IDX = CW'(SAMPLES - 1);
   localparam int PW = SAMPLE_BITS + red_pkg::PI_SPLIT;
   localparam int SW = SAMPLE_BITS + 43;
   localparam logic [red_pkg::PI_SPLIT-1:0] PI_HI =
      red_pkg::PI_SPLIT'(red_pkg::PI_Q40 >> red_pkg::PI_SPLIT);
   localparam logic [red_pkg::PI_SPLIT-1:0] PI_LO = red_pkg::PI_SPLIT'(red_pkg::PI_Q40);

   typedef struct packed {
      red_pkg::event_desc_type desc;
      logic [CW-1:0]           idx;
      logic                    last;
   } tag_type;

   red_pkg::emit_state_type state_ff;
   red_pkg::emit_state_type state_in;

   logic                    advance;
   logic                    issue;
   logic [CW-1:0]           idx_ff;
   logic [CW-1:0]           idx_in;
   red_pkg::event_desc_type desc_ff;

   logic                    v1_ff;
   tag_type                 tag1_ff;
   tag_type                 tag1_in;
   logic                    v2_ff;
   tag_type                 tag2_ff;
   logic                    neg2_ff;
   logic [15:0]             magn2_ff;
   logic [PW-1:0]           p_hi_ff;
   logic [PW-1:0]           p_lo_ff;

   logic [SAMPLE_BITS-1:0]  raw1;
   logic                    neg1;
   logic [SAMPLE_BITS-1:0]  mag1;
   logic [PW-1:0]           p_hi_in;
   logic [PW-1:0]           p_lo_in;

   logic [SW-1:0]           sum3;
   logic [17:0]             rmag3;
   logic [17:0]             phase3;

   logic                    rsp_valid_ff;
   tag_type                 out_tag_ff;
   logic [15:0]             out_magn_ff;
   logic [17:0]             out_phase_ff;

   assign advance = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         red_pkg::EMIT_IDLE: begin
            if (q_valid) begin
               state_in = red_pkg::EMIT_RUN;
            end
         end
         red_pkg::EMIT_RUN: begin
            if (advance && (idx_ff == LAST_IDX)) begin
               state_in = red_pkg::EMIT_IDLE;
            end
         end
         default: begin
            state_in = red_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      issue = 1'b0;
      case (state_ff)
         red_pkg::EMIT_IDLE: begin
            q_pop = q_valid;
         end
         red_pkg::EMIT_RUN: begin
            issue = advance;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_comb begin
      idx_in = idx_ff;
      if (q_pop) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   assign bank_free.valid = issue && (idx_ff == LAST_IDX);
   assign bank_free.bank = desc_ff.bank;
   assign rd_en = advance;
   assign rd_addr = {desc_ff.bank, idx_ff};

   always_comb begin
      tag1_in.desc = desc_ff;
      tag1_in.idx = idx_ff;
      tag1_in.last = (idx_ff == LAST_IDX);
      raw1 = rd_data[SAMPLE_BITS-1:0];
      neg1 = raw1[SAMPLE_BITS-1];
      mag1 = neg1 ? (~raw1 + SAMPLE_BITS'(1)) : raw1;
      p_hi_in = PW'(mag1) * PW'(PI_HI);
      p_lo_in = PW'(mag1) * PW'(PI_LO);
   end

   always_comb begin
      sum3 = (SW'(p_hi_ff) << red_pkg::PI_SPLIT) + SW'(p_lo_ff)
             + (SW'(1) << (red_pkg::PI_FRAC - 1));
      rmag3 = 18'(sum3 >> red_pkg::PI_FRAC);
      phase3 = neg2_ff ? (~rmag3 + 18'd1) : rmag3;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= red_pkg::EMIT_IDLE;
         idx_ff <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         if (advance) begin
            v1_ff <= issue;
            v2_ff <= v1_ff;
            rsp_valid_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         desc_ff <= q_data;
      end
      if (advance) begin
         tag1_ff <= tag1_in;
         tag2_ff <= tag1_ff;
         neg2_ff <= neg1;
         magn2_ff <= rd_data[DW-1:SAMPLE_BITS];
         p_hi_ff <= p_hi_in;
         p_lo_ff <= p_lo_in;
         out_tag_ff <= tag2_ff;
         out_magn_ff <= magn2_ff;
         out_phase_ff <= phase3;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_channel = out_tag_ff.desc.channel;
   assign rsp_timestamp = out_tag_ff.desc.timestamp;
   assign rsp_pulse_flag = out_tag_ff.desc.pulse_flag;
   assign rsp_sample_index = 5'(out_tag_ff.idx);
   assign rsp_magnitude = out_magn_ff;
   assign rsp_phase_radians = $signed(out_phase_ff);
   assign rsp_last = out_tag_ff.last;
   assign rsp_good_events = out_tag_ff.desc.good_events;
   assign rsp_bad_events = out_tag_ff.desc.bad_events;
   assign rsp_skipped_words = out_tag_ff.desc.skipped_words;

endmodule

>>> sv/readout_event_deframer_core.sv
// Readout event deframer. Words enter on the req_ channel (valid/ready), one per cycle.
// While hunting, words whose low half is not the sync pattern are skipped and counted.
// A sync word, a header word and SAMPLES data words form an event; a sync pattern in a
// data word drops the event. Each good event leaves on the rsp_ channel as SAMPLES items,
// one per cycle, with rsp_last on the final one. csr_ writes set the channel offset,
// which is taken at the header word.
// The input side accepts one word per cycle. Data words go into a two-bank sample
// memory; when both banks still hold events waiting for output, req_ready drops on
// data words until the output side frees a bank.
// The first item of an event passes the event queue, the descriptor register, the
// sample memory read register, the product registers and the output registers. The
// output side then gives one item per cycle and returns to idle between events.
// When the receiver holds rsp_ready low, the output pipeline stops with its item held.
// Synchronous reset returns to hunting, clears the counters and the offset, and
// empties the event queue; no item is presented until new words arrive.
module readout_event_deframer_core #(
   parameter int SAMPLES = red_pkg::SAMPLES_DEF,
   parameter int SAMPLE_BITS = red_pkg::SAMPLE_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [31:0]        req_word,
   input  logic               csr_write_enable,
   input  logic [7:0]         csr_write_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [8:0]         rsp_channel,
   output logic [31:0]        rsp_timestamp,
   output logic               rsp_pulse_flag,
   output logic [4:0]         rsp_sample_index,
   output logic [15:0]        rsp_magnitude,
   output logic signed [17:0] rsp_phase_radians,
   output logic               rsp_last,
   output logic [15:0]        rsp_good_events,
   output logic [15:0]        rsp_bad_events,
   output logic [15:0]        rsp_skipped_words
);

   localparam int CW = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int AW = CW + 1;
   localparam int DW = 16 + SAMPLE_BITS;
   localparam int DEPTH = 1 << AW;

   logic                    wr_en;
   logic [AW-1:0]           wr_addr;
   logic [DW-1:0]           wr_data;
   logic                    rd_en;
   logic [AW-1:0]           rd_addr;
   logic [DW-1:0]           rd_data;
   logic                    q_push;
   logic                    q_full;
   logic                    q_pop;
   logic                    q_valid;
   red_pkg::event_desc_type q_push_data;
   red_pkg::event_desc_type q_pop_data;
   red_pkg::bank_free_type  bank_free;

   red_front #(
      .SAMPLES(SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .q_push(q_push),
      .q_data(q_push_data),
      .q_full(q_full),
      .bank_free(bank_free)
   );

   red_ram #(
      .WIDTH(DW),
      .DEPTH(DEPTH)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   red_evq u_evq (
      .clock(clock),
      .reset(reset),
      .push(q_push),
      .push_data(q_push_data),
      .full(q_full),
      .pop(q_pop),
      .pop_valid(q_valid),
      .pop_data(q_pop_data)
   );

   red_back #(
      .SAMPLES(SAMPLES),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_pop(q_pop),
      .q_data(q_pop_data),
      .rd_en(rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .bank_free(bank_free),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_channel(rsp_channel),
      .rsp_timestamp(rsp_timestamp),
      .rsp_pulse_flag(rsp_pulse_flag),
      .rsp_sample_index(rsp_sample_index),
      .rsp_magnitude(rsp_magnitude),
      .rsp_phase_radians(rsp_phase_radians),
      .rsp_last(rsp_last),
      .rsp_good_events(rsp_good_events),
      .rsp_bad_events(rsp_bad_events),
      .rsp_skipped_words(rsp_skipped_words)
   );

   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("Event pushed into a full queue.");

   a_event_continuous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=> rsp_valid)
      else $error("Gap inside an event on the output.");

   a_index_steps: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last |=>
         rsp_sample_index == 5'($past(rsp_sample_index) + 5'd1))
      else $error("Sample index did not advance by one.");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_sample_index == 5'(SAMPLES - 1))
      else $error("Last item carries the wrong sample index.");

endmodule

>>> test/readout_event_deframer_core_test.sv
module readout_event_deframer_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SAMPLES = red_pkg::SAMPLES_DEF;
   localparam logic [15:0] SYNC_LOW = 16'hAAAA;
   localparam longint unsigned PI_Q40_FIXED = 64'h3243F6A8885;
   localparam int CYCLE_LIMIT = 1500000;
   localparam int REPORT_LIMIT = 30;

   typedef struct packed {
      logic [8:0]         channel;
      logic [31:0]        timestamp;
      logic               pulse_flag;
      logic [4:0]         sample_index;
      logic [15:0]        magnitude;
      logic signed [17:0] phase_radians;
      logic               last;
      logic [15:0]        good_events;
      logic [15:0]        bad_events;
      logic [15:0]        skipped_words;
   } sample_result_type;

   class deframer_scoreboard;
      red_pkg::frame_state_type frame;
      int fill;
      logic [7:0] offset;
      logic [15:0] sync_high;
      logic [8:0] hdr_channel;
      logic hdr_pulse;
      logic [15:0] hdr_ts_low;
      logic [31:0] samples [SAMPLES];
      logic [15:0] good_cnt;
      logic [15:0] bad_cnt;
      logic [15:0] skip_cnt;
      sample_result_type pending_samples [$];
      int failures;
      int checked;
      int kept;
      int dropped;

      function new();
         frame = red_pkg::FRAME_HUNT;
         fill = 0;
         offset = '0;
         sync_high = '0;
         hdr_channel = '0;
         hdr_pulse = 1'b0;
         hdr_ts_low = '0;
         good_cnt = '0;
         bad_cnt = '0;
         skip_cnt = '0;
         failures = 0;
         checked = 0;
         kept = 0;
         dropped = 0;
      endfunction

      function void set_offset(logic [7:0] value);
         offset = value;
      endfunction

      function logic [15:0] bump(logic [15:0] count);
         return (count == 16'hFFFF) ? count : count + 16'd1;
      endfunction

      function logic [17:0] scaled_phase(logic [15:0] raw);
         longint unsigned mag;
         longint unsigned scaled;
         mag = raw[15] ? 64'd65536 - 64'(raw) : 64'(raw);
         scaled = (mag * PI_Q40_FIXED + (64'd1 << 39)) >> 40;
         return raw[15] ? 18'(-scaled) : 18'(scaled);
      endfunction

      function void deframe_word(logic [31:0] w);
         sample_result_type item;
         case (frame)
            red_pkg::FRAME_HEADER: begin
               hdr_channel = 9'(w[7:0]) + 9'(offset);
               hdr_pulse = w[8];
               hdr_ts_low = w[24:9];
               fill = 0;
               frame = red_pkg::FRAME_DATA;
            end
            red_pkg::FRAME_DATA: begin
               if (w[15:0] == SYNC_LOW) begin
                  bad_cnt = bump(bad_cnt);
                  dropped++;
                  frame = red_pkg::FRAME_HUNT;
                  fill = 0;
               end else begin
                  samples[fill] = w;
                  fill++;
                  if (fill == SAMPLES) begin
                     good_cnt = bump(good_cnt);
                     kept++;
                     frame = red_pkg::FRAME_HUNT;
                     fill = 0;
                     for (int k = 0; k < SAMPLES; k++) begin
                        item.channel = hdr_channel;
                        item.timestamp = {sync_high, hdr_ts_low};
                        item.pulse_flag = hdr_pulse;
                        item.sample_index = 5'(k);
                        item.magnitude = samples[k][31:16];
                        item.phase_radians = scaled_phase(samples[k][15:0]);
                        item.last = (k == SAMPLES - 1);
                        item.good_events = good_cnt;
                        item.bad_events = bad_cnt;
                        item.skipped_words = skip_cnt;
                        pending_samples.push_back(item);
                     end
                  end
               end
            end
            default: begin
               if (w[15:0] == SYNC_LOW) begin
                  sync_high = w[31:16];
                  frame = red_pkg::FRAME_HEADER;
               end else begin
                  skip_cnt = bump(skip_cnt);
               end
            end
         endcase
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_sample(sample_result_type got);
         sample_result_type want;
         if (pending_samples.size() == 0) begin
            failures++;
            if (failures <= REPORT_LIMIT)
               $display("%0t: unexpected item, expected none, actual index %0d channel %0h",
                        $time, got.sample_index, got.channel);
            return;
         end
         want = pending_samples.pop_front();
         checked++;
         compare_field("channel", 32'(want.channel), 32'(got.channel));
         compare_field("timestamp", want.timestamp, got.timestamp);
         compare_field("pulse_flag", 32'(want.pulse_flag), 32'(got.pulse_flag));
         compare_field("sample_index", 32'(want.sample_index), 32'(got.sample_index));
         compare_field("magnitude", 32'(want.magnitude), 32'(got.magnitude));
         compare_field("phase_radians", 32'(want.phase_radians), 32'(got.phase_radians));
         compare_field("last", 32'(want.last), 32'(got.last));
         compare_field("good_events", 32'(want.good_events), 32'(got.good_events));
         compare_field("bad_events", 32'(want.bad_events), 32'(got.bad_events));
         compare_field("skipped_words", 32'(want.skipped_words), 32'(got.skipped_words));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [31:0] req_word = '0;
   logic csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [8:0] rsp_channel;
   logic [31:0] rsp_timestamp;
   logic rsp_pulse_flag;
   logic [4:0] rsp_sample_index;
   logic [15:0] rsp_magnitude;
   logic signed [17:0] rsp_phase_radians;
   logic rsp_last;
   logic [15:0] rsp_good_events;
   logic [15:0] rsp_bad_events;
   logic [15:0] rsp_skipped_words;

   deframer_scoreboard board;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int word_count = 0;
   int cycle_count = 0;

   readout_event_deframer_core #(
      .SAMPLES(SAMPLES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_word(req_word),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_channel(rsp_channel),
      .rsp_timestamp(rsp_timestamp),
      .rsp_pulse_flag(rsp_pulse_flag),
      .rsp_sample_index(rsp_sample_index),
      .rsp_magnitude(rsp_magnitude),
      .rsp_phase_radians(rsp_phase_radians),
      .rsp_last(rsp_last),
      .rsp_good_events(rsp_good_events),
      .rsp_bad_events(rsp_bad_events),
      .rsp_skipped_words(rsp_skipped_words)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin : monitor
      sample_result_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            board.deframe_word(req_word);
         if (rsp_valid && rsp_ready) begin
            got = {rsp_channel, rsp_timestamp, rsp_pulse_flag, rsp_sample_index, rsp_magnitude,
                   rsp_phase_radians, rsp_last, rsp_good_events, rsp_bad_events,
                   rsp_skipped_words};
            board.check_sample(got);
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   task automatic push_word(input logic [31:0] w);
      if (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
         while ($urandom_range(99) < send_gap_pct)
            @(negedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      @(negedge clock);
      word_count++;
   endtask

   task automatic stop_words();
      req_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic settle();
      while (board.pending_samples.size() != 0)
         @(negedge clock);
      repeat (SAMPLES + 8) @(negedge clock);
   endtask

   task automatic write_offset(input logic [7:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      board.set_offset(value);
      @(negedge clock);
   endtask

   function automatic logic [31:0] plain_word();
      logic [31:0] w;
      w = $urandom;
      if (w[15:0] == SYNC_LOW)
         w[0] = 1'b1;
      return w;
   endfunction

   // An abort position equal to SAMPLES gives a complete event.
   task automatic send_event(input int abort_at);
      logic [31:0] hdr;
      push_word({16'($urandom), SYNC_LOW});
      hdr = $urandom;
      if ($urandom_range(7) == 0)
         hdr[15:0] = SYNC_LOW;
      push_word(hdr);
      for (int i = 0; i < abort_at; i++)
         push_word(plain_word());
      if (abort_at < SAMPLES)
         push_word({16'($urandom), SYNC_LOW});
   endtask

   task automatic random_traffic(input int quota);
      int start;
      int pick;
      start = word_count;
      while (word_count - start < quota) begin
         pick = $urandom_range(99);
         if (pick < 70)
            send_event(SAMPLES);
         else if (pick < 80)
            send_event($urandom_range(SAMPLES - 1));
         else if (pick < 88)
            push_word(plain_word());
         else if (pick < 94)
            push_word($urandom);
         else
            push_word({16'($urandom), SYNC_LOW});
      end
   endtask

   task automatic directed_words();
      logic [31:0] corner_words [8];
      corner_words = '{32'h00000000, 32'hFFFF7FFF, 32'h80008000, 32'h0001FFFF,
                       32'h7FFF0001, 32'hFFFF8001, 32'h0000FFFE, 32'h12340000};
      push_word(32'h00000000);
      push_word(32'hFFFFFFFF);
      push_word(32'h0000AAAB);
      push_word(32'hFFFFAAAA);
      push_word(32'hFFFFFFFF);
      foreach (corner_words[i])
         push_word(corner_words[i]);
      for (int i = 8; i < SAMPLES; i++)
         push_word(plain_word());
      push_word(32'h0000AAAA);
      push_word(32'h0000AAAA);
      push_word(plain_word());
      push_word(plain_word());
      push_word(32'hAAAAAAAA);
      push_word(32'h5555AAAA);
      push_word(32'h00000100);
      push_word(32'hFFFFAAAA);
   endtask

   initial begin
      int gap_modes [4];
      int stall_modes [4];
      int quotas [4];
      logic [7:0] offsets [4];
      board = new();
      gap_modes = '{0, 48, 0, 18};
      stall_modes = '{0, 0, 48, 18};
      quotas = '{30, 30, 50, 30};
      offsets = '{8'd0, 8'($urandom_range(1, 254)), 8'd128, 8'($urandom_range(255))};
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_offset(8'd255);
      directed_words();
      stop_words();
      settle();

      for (int p = 0; p < 4; p++) begin
         send_gap_pct = gap_modes[p];
         rsp_stall_pct = stall_modes[p];
         write_offset(offsets[p]);
         random_traffic(quotas[p]);
         stop_words();
         settle();
      end

      $display("Checked %0d result items from %0d accepted words: %0d events kept, %0d dropped.",
               board.checked, word_count, board.kept, board.dropped);
      $display("Final counters: good %0d, bad %0d, skipped %0d.",
               board.good_cnt, board.bad_cnt, board.skip_cnt);
      if (board.failures == 0 && board.pending_samples.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
